/* rtl/isos_pkg.sv */
// ----------------------------------------------------------------------------
// isos_pkg: shared constants, calibration tables and beat types
// Field widths, the IR-to-distance calibration curve and the structs that
// carry a point between the pipeline stages of the IR scan segmenter.
// ----------------------------------------------------------------------------
package isos_pkg;

  localparam int unsigned SAMPLES_PER_POINT = 3;
  localparam int unsigned MAX_OBJECTS       = 16;
  localparam int unsigned CURVE_POINTS      = 15;

  // Field widths fixed by the interface.
  localparam int unsigned ANGLE_W = 8;
  localparam int unsigned IR_W    = 12;
  localparam int unsigned DIST_W  = 14;
  localparam int unsigned NUM_W   = 4;

  // Accumulator sizing.
  localparam int unsigned SUM_W = $clog2(SAMPLES_PER_POINT * ((2 ** IR_W) - 1) + 1);
  localparam int unsigned CNT_W = (SAMPLES_PER_POINT > 1) ? $clog2(SAMPLES_PER_POINT) : 1;
  localparam int unsigned OBJ_W = $clog2(MAX_OBJECTS + 1);

  // Average by reciprocal multiply: floor(sum * RECIP / 2^RECIP_SHIFT).
  // The rounding excess stays well below 1/SAMPLES_PER_POINT for any sum.
  localparam int unsigned RECIP_SHIFT = 20;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((2 ** RECIP_SHIFT) + SAMPLES_PER_POINT - 1) / SAMPLES_PER_POINT);
  localparam int unsigned DIVP_W = SUM_W + RECIP_W;

  // Calibration curve. Slopes are Q7.16 of Q6.8 cm per raw count.
  localparam int unsigned CM_W    = 6;
  localparam int unsigned SLOPE_W = 23;
  localparam int unsigned SEG_W   = $clog2(CURVE_POINTS - 1);
  // The widest segment spans 222 counts, so the offset into it fits 8 bits.
  localparam int unsigned DELTA_W = 8;
  localparam int unsigned FRAC_SHIFT = 16;
  localparam int unsigned PROD_W  = DELTA_W + SLOPE_W;

  localparam logic [IR_W-1:0] CAL_IR [CURVE_POINTS] = '{
    12'd1499, 12'd1277, 12'd1147, 12'd1087, 12'd987, 12'd955, 12'd919, 12'd877,
    12'd842,  12'd833,  12'd803,  12'd795,  12'd779, 12'd751, 12'd731
  };

  localparam logic [CM_W-1:0] CAL_CM [CURVE_POINTS] = '{
    6'd9,  6'd12, 6'd15, 6'd18, 6'd21, 6'd24, 6'd27, 6'd30,
    6'd33, 6'd36, 6'd39, 6'd42, 6'd45, 6'd48, 6'd50
  };

  localparam logic [SLOPE_W-1:0] CAL_SLOPE [CURVE_POINTS-1] = '{
    23'd226719,  23'd387167,  23'd838861,  23'd503316,  23'd1572864,
    23'd1398101, 23'd1198373, 23'd1438047, 23'd5592405, 23'd1677722,
    23'd6291456, 23'd3145728, 23'd1797559, 23'd1677722
  };

  localparam logic [DIST_W-1:0] NEAR_THRESHOLD_RST = 14'd11520;

  // Averaged point on its way to the calibration curve.
  typedef struct packed {
    logic               clear;
    logic [ANGLE_W-1:0] angle;
    logic [IR_W-1:0]    avg;
  } avg_beat_t;

  // Calibrated point on its way to segmentation.
  typedef struct packed {
    logic               clear;
    logic [ANGLE_W-1:0] angle;
    logic [DIST_W-1:0]  distance;
  } dist_beat_t;

endpackage

/* rtl/isos_accum.sv */
// ----------------------------------------------------------------------------
// isos_accum: sample accumulator and averaging stages
// Sums raw IR samples per point, then divides by the sample count through a
// registered reciprocal multiply.
// ----------------------------------------------------------------------------
module isos_accum (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           scan_start_i,
  input  logic [isos_pkg::ANGLE_W-1:0]   angle_i,
  input  logic [isos_pkg::IR_W-1:0]      raw_ir_i,
  output logic                           avg_valid_o,
  input  logic                           avg_ready_i,
  output isos_pkg::avg_beat_t            avg_o
);
  import isos_pkg::*;

  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               clr_pend_q, clr_pend_d;
  logic [SUM_W-1:0]   sum_base, sum_new;
  logic [CNT_W-1:0]   cnt_base;
  logic               complete, fire;

  logic               sum_valid_q;
  logic [SUM_W-1:0]   psum_q;
  logic [ANGLE_W-1:0] pangle_q;
  logic               pclear_q;
  logic               avg_valid_q;
  avg_beat_t          avg_q;
  logic               rdy_sum, rdy_avg;
  logic [DIVP_W-1:0]  quot_prod;

  assign rdy_avg    = !avg_valid_q || avg_ready_i;
  assign rdy_sum    = !sum_valid_q || rdy_avg;
  assign in_ready_o = rdy_sum;
  assign fire       = in_valid_i && rdy_sum;

  // A scan start drops the partial sum before this sample is added.
  always_comb begin
    sum_base   = scan_start_i ? '0 : sum_q;
    cnt_base   = scan_start_i ? '0 : cnt_q;
    sum_new    = sum_base + SUM_W'(raw_ir_i);
    complete   = (cnt_base == CNT_W'(SAMPLES_PER_POINT - 1));
    sum_d      = sum_q;
    cnt_d      = cnt_q;
    clr_pend_d = clr_pend_q;
    if (fire) begin
      if (complete) begin
        sum_d      = '0;
        cnt_d      = '0;
        clr_pend_d = 1'b0;
      end else begin
        sum_d      = sum_new;
        cnt_d      = cnt_base + CNT_W'(1);
        clr_pend_d = clr_pend_q | scan_start_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q      <= '0;
      cnt_q      <= '0;
      clr_pend_q <= 1'b0;
    end else begin
      sum_q      <= sum_d;
      cnt_q      <= cnt_d;
      clr_pend_q <= clr_pend_d;
    end
  end

  // Completed sum stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
    end else if (rdy_sum) begin
      sum_valid_q <= fire && complete;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && complete) begin
      psum_q   <= sum_new;
      pangle_q <= angle_i;
      pclear_q <= scan_start_i | clr_pend_q;
    end
  end

  assign quot_prod = DIVP_W'(psum_q) * DIVP_W'(RECIP);

  // Average stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_valid_q <= 1'b0;
    end else if (rdy_avg) begin
      avg_valid_q <= sum_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_avg && sum_valid_q) begin
      avg_q.clear <= pclear_q;
      avg_q.angle <= pangle_q;
      avg_q.avg   <= quot_prod[RECIP_SHIFT +: IR_W];
    end
  end

  assign avg_valid_o = avg_valid_q;
  assign avg_o       = avg_q;

endmodule

/* rtl/isos_curve.sv */
// ----------------------------------------------------------------------------
// isos_curve: piecewise-linear calibration
// Picks the curve segment with a row of comparators, then interpolates with
// one registered multiply. Both ends of the curve clamp.
// ----------------------------------------------------------------------------
module isos_curve (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 avg_valid_i,
  output logic                 avg_ready_o,
  input  isos_pkg::avg_beat_t  avg_i,
  output logic                 dist_valid_o,
  input  logic                 dist_ready_i,
  output isos_pkg::dist_beat_t dist_o
);
  import isos_pkg::*;

  logic [SEG_W-1:0]   seg;
  logic [IR_W-1:0]    delta_full;
  logic [DELTA_W-1:0] delta_d;
  logic [CM_W-1:0]    base_d;
  logic [SLOPE_W-1:0] slope_d;
  logic               clamp_hi, clamp_lo;

  logic               sel_valid_q;
  logic [DELTA_W-1:0] delta_q;
  logic [CM_W-1:0]    base_q;
  logic [SLOPE_W-1:0] slope_q;
  logic [ANGLE_W-1:0] angle_q;
  logic               clear_q;

  logic               dist_valid_q;
  dist_beat_t         dist_q;
  logic [PROD_W-1:0]  prod;
  logic               rdy_sel, rdy_dist;

  assign rdy_dist    = !dist_valid_q || dist_ready_i;
  assign rdy_sel     = !sel_valid_q || rdy_dist;
  assign avg_ready_o = rdy_sel;

  // Breakpoints fall, so the last breakpoint at or above the average marks
  // the segment that holds it.
  always_comb begin
    seg = '0;
    for (int i = 1; i < int'(CURVE_POINTS) - 1; i++) begin
      if (avg_i.avg <= CAL_IR[i]) begin
        seg = SEG_W'(i);
      end
    end
    clamp_hi   = (avg_i.avg >= CAL_IR[0]);
    clamp_lo   = (avg_i.avg <= CAL_IR[CURVE_POINTS-1]);
    delta_full = CAL_IR[seg] - avg_i.avg;
    delta_d    = delta_full[DELTA_W-1:0];
    base_d     = CAL_CM[seg];
    slope_d    = CAL_SLOPE[seg];
    if (clamp_hi) begin
      delta_d = '0;
      base_d  = CAL_CM[0];
    end else if (clamp_lo) begin
      delta_d = '0;
      base_d  = CAL_CM[CURVE_POINTS-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_valid_q <= 1'b0;
    end else if (rdy_sel) begin
      sel_valid_q <= avg_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_sel && avg_valid_i) begin
      delta_q <= delta_d;
      base_q  <= base_d;
      slope_q <= slope_d;
      angle_q <= avg_i.angle;
      clear_q <= avg_i.clear;
    end
  end

  assign prod = PROD_W'(delta_q) * PROD_W'(slope_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_valid_q <= 1'b0;
    end else if (rdy_dist) begin
      dist_valid_q <= sel_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_dist && sel_valid_q) begin
      dist_q.clear    <= clear_q;
      dist_q.angle    <= angle_q;
      dist_q.distance <= DIST_W'({base_q, 8'h00}) + DIST_W'(prod >> FRAC_SHIFT);
    end
  end

  assign dist_valid_o = dist_valid_q;
  assign dist_o       = dist_q;

endmodule

/* rtl/isos_segment.sv */
// ----------------------------------------------------------------------------
// isos_segment: threshold segmentation and result register
// Opens and closes objects against the near threshold, tracks the narrowest
// closed object of the scan and holds the result beat.
// ----------------------------------------------------------------------------
module isos_segment (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [isos_pkg::DIST_W-1:0]     cfg_wdata_i,
  input  logic                            dist_valid_i,
  output logic                            dist_ready_o,
  input  isos_pkg::dist_beat_t            dist_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [isos_pkg::ANGLE_W-1:0]    point_angle_o,
  output logic [isos_pkg::DIST_W-1:0]     distance_o,
  output logic                            object_closed_o,
  output logic [isos_pkg::NUM_W-1:0]      object_number_o,
  output logic [isos_pkg::ANGLE_W-1:0]    object_start_o,
  output logic [isos_pkg::ANGLE_W-1:0]    object_end_o,
  output logic [isos_pkg::NUM_W-1:0]      smallest_number_o,
  output logic [isos_pkg::ANGLE_W-1:0]    smallest_start_o,
  output logic [isos_pkg::ANGLE_W-1:0]    smallest_end_o,
  output logic                            table_overflow_o
);
  import isos_pkg::*;

  logic [DIST_W-1:0]  thresh_q;
  logic               inside_q, inside_d, inside_c;
  logic [ANGLE_W-1:0] open_q, open_d, open_c;
  logic [OBJ_W-1:0]   found_q, found_d, found_c;
  logic [ANGLE_W-1:0] bwidth_q, bwidth_d, bwidth_c;
  logic [NUM_W-1:0]   bnum_q, bnum_d, bnum_c;
  logic [ANGLE_W-1:0] bstart_q, bstart_d, bstart_c;
  logic [ANGLE_W-1:0] bend_q, bend_d, bend_c;

  logic               closed, ovf;
  logic [NUM_W-1:0]   onum;
  logic [ANGLE_W-1:0] ostart, oend, width;
  logic               fire;
  logic               out_valid_q;

  assign dist_ready_o = !out_valid_q || out_ready_i;
  assign fire         = dist_valid_i && dist_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= NEAR_THRESHOLD_RST;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    // A scan start seen on any sample of this point wipes the scan state.
    inside_c = dist_i.clear ? 1'b0 : inside_q;
    open_c   = dist_i.clear ? '0 : open_q;
    found_c  = dist_i.clear ? '0 : found_q;
    bwidth_c = dist_i.clear ? '0 : bwidth_q;
    bnum_c   = dist_i.clear ? '0 : bnum_q;
    bstart_c = dist_i.clear ? '0 : bstart_q;
    bend_c   = dist_i.clear ? '0 : bend_q;

    inside_d = inside_c;
    open_d   = open_c;
    found_d  = found_c;
    bwidth_d = bwidth_c;
    bnum_d   = bnum_c;
    bstart_d = bstart_c;
    bend_d   = bend_c;

    closed = 1'b0;
    ovf    = 1'b0;
    onum   = '0;
    ostart = '0;
    oend   = '0;
    width  = (dist_i.angle >= open_c) ? (dist_i.angle - open_c) : '0;

    if (dist_i.distance < thresh_q) begin
      if (!inside_c) begin
        inside_d = 1'b1;
        open_d   = dist_i.angle;
      end
    end else if (inside_c) begin
      inside_d = 1'b0;
      closed   = 1'b1;
      ostart   = open_c;
      oend     = dist_i.angle;
      if (found_c >= OBJ_W'(MAX_OBJECTS)) begin
        ovf = 1'b1;
      end else begin
        onum = found_c[NUM_W-1:0];
        if (found_c == '0 || width < bwidth_c) begin
          bwidth_d = width;
          bnum_d   = onum;
          bstart_d = open_c;
          bend_d   = dist_i.angle;
        end
        found_d = found_c + OBJ_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      open_q   <= '0;
      found_q  <= '0;
      bwidth_q <= '0;
      bnum_q   <= '0;
      bstart_q <= '0;
      bend_q   <= '0;
    end else if (fire) begin
      inside_q <= inside_d;
      open_q   <= open_d;
      found_q  <= found_d;
      bwidth_q <= bwidth_d;
      bnum_q   <= bnum_d;
      bstart_q <= bstart_d;
      bend_q   <= bend_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (dist_ready_o) begin
      out_valid_q <= dist_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      point_angle_o     <= dist_i.angle;
      distance_o        <= dist_i.distance;
      object_closed_o   <= closed;
      object_number_o   <= onum;
      object_start_o    <= ostart;
      object_end_o      <= oend;
      smallest_number_o <= bnum_d;
      smallest_start_o  <= bstart_d;
      smallest_end_o    <= bend_d;
      table_overflow_o  <= ovf;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/ir_scan_object_segmenter_top.sv */
// ----------------------------------------------------------------------------
// ir_scan_object_segmenter_top: IR scan object segmenter
// Averages raw IR samples into points, calibrates them to distance and
// segments the scan into objects, keeping the narrowest one.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one raw IR sample per beat (scan_start, angle,
// raw_ir) under valid/ready. Every third accepted sample completes a point,
// and only a completed point produces a beat on the output channel; other
// samples are absorbed into the running sum.
// The pipeline is five registers deep (completed sum, average, segment select,
// distance, result), and the first one loads on the edge that accepts the
// input beat. One sample is accepted every cycle while in_ready is high; the
// rate is set by the accumulator, whose running sum feeds back on itself, and
// every later stage is fully pipelined.
// Each stage has its own valid bit and moves whenever the stage after it is
// empty or draining, so bubbles collapse and input is taken while a finished
// result waits. When the receiver holds out_ready low, the pipeline fills up
// and in_ready falls only once every stage holds a point.
// Reset empties the pipeline, clears sum, sample count and all segmentation
// state, and loads the near threshold with 45 cm. The user must write the
// threshold register via cfg_we_i/cfg_wdata_i only while idle (not enforced).
// ----------------------------------------------------------------------------
module ir_scan_object_segmenter_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [isos_pkg::DIST_W-1:0]     cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            scan_start_i,
  input  logic [isos_pkg::ANGLE_W-1:0]    angle_i,
  input  logic [isos_pkg::IR_W-1:0]       raw_ir_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [isos_pkg::ANGLE_W-1:0]    point_angle_o,
  output logic [isos_pkg::DIST_W-1:0]     distance_o,
  output logic                            object_closed_o,
  output logic [isos_pkg::NUM_W-1:0]      object_number_o,
  output logic [isos_pkg::ANGLE_W-1:0]    object_start_o,
  output logic [isos_pkg::ANGLE_W-1:0]    object_end_o,
  output logic [isos_pkg::NUM_W-1:0]      smallest_number_o,
  output logic [isos_pkg::ANGLE_W-1:0]    smallest_start_o,
  output logic [isos_pkg::ANGLE_W-1:0]    smallest_end_o,
  output logic                            table_overflow_o
);
  import isos_pkg::*;

  // Averaged points leaving the accumulator.
  logic       avg_valid, avg_ready;
  avg_beat_t  avg_beat;

  // Calibrated points entering segmentation.
  logic       dist_valid, dist_ready;
  dist_beat_t dist_beat;

  // Sum samples and divide by the point size. A scan start that lands on a
  // sample in the middle of a point is remembered and rides on the point.
  isos_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .scan_start_i (scan_start_i),
    .angle_i      (angle_i),
    .raw_ir_i     (raw_ir_i),
    .avg_valid_o  (avg_valid),
    .avg_ready_i  (avg_ready),
    .avg_o        (avg_beat)
  );

  // Segment select, then one multiply for the interpolation.
  isos_curve u_curve (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .avg_valid_i  (avg_valid),
    .avg_ready_o  (avg_ready),
    .avg_i        (avg_beat),
    .dist_valid_o (dist_valid),
    .dist_ready_i (dist_ready),
    .dist_o       (dist_beat)
  );

  // Segmentation state lives next to the result register, so each point sees
  // the state left by the point before it.
  isos_segment u_segment (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .dist_valid_i      (dist_valid),
    .dist_ready_o      (dist_ready),
    .dist_i            (dist_beat),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .point_angle_o     (point_angle_o),
    .distance_o        (distance_o),
    .object_closed_o   (object_closed_o),
    .object_number_o   (object_number_o),
    .object_start_o    (object_start_o),
    .object_end_o      (object_end_o),
    .smallest_number_o (smallest_number_o),
    .smallest_start_o  (smallest_start_o),
    .smallest_end_o    (smallest_end_o),
    .table_overflow_o  (table_overflow_o)
  );

endmodule
